// ===== hw/rtl/rtb_pkg.sv =====
package rtb_pkg;

	localparam int unsigned NumChan    = 4;
	localparam int unsigned NumColour  = 3;
	localparam int unsigned ChanW      = 8;
	localparam int unsigned ProdW      = 2 * ChanW;
	localparam int unsigned AlphaChan  = 3;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [ProdW-1:0] prod_t;
	typedef logic [NumChan*ChanW-1:0] rgba_t;

	typedef enum logic [1:0] {
		MODE_OPAQUE    = 2'd0,
		MODE_ADD       = 2'd1,
		MODE_ALPHA     = 2'd2,
		MODE_ALPHA_ALT = 2'd3
	} blend_mode_t;

	localparam chan_t ChanMax = '1;

	// Exact floor(x / 255) for any x up to 255 * 255, using the usual
	// add-and-shift identity instead of a divider.
	function automatic chan_t div255(input prod_t x);
		logic [ProdW:0] t;
		t = {1'b0, x} + {{ProdW{1'b0}}, 1'b1} + {{(ProdW + 1 - ChanW){1'b0}}, x[ProdW-1:ChanW]};
		return t[ProdW-1:ChanW];
	endfunction

	function automatic chan_t get_chan(input rgba_t px, input int unsigned idx);
		return px[idx*ChanW +: ChanW];
	endfunction

endpackage

// ===== hw/rtl/rtb_if.sv =====
interface rtb_frag_if;
	import rtb_pkg::*;

	logic        valid;
	logic        ready;
	rgba_t       texel;
	rgba_t       tint_color;
	rgba_t       dest_pixel;
	blend_mode_t blend_mode;

	modport source (output valid, texel, tint_color, dest_pixel, blend_mode, input ready);
	modport sink (input valid, texel, tint_color, dest_pixel, blend_mode, output ready);
endinterface

interface rtb_pix_if;
	import rtb_pkg::*;

	logic  valid;
	logic  ready;
	rgba_t result_pixel;

	modport source (output valid, result_pixel, input ready);
	modport sink (input valid, result_pixel, output ready);
endinterface

// ===== hw/rtl/rgba_tint_and_blend.sv =====
// Channel | Direction | Contents
// frag    | in        | texel, tint_color, dest_pixel (RGBA8), blend_mode
// pix     | out       | result_pixel (RGBA8)
//
// One fragment per clock sustained while pix keeps taking results; the result is
// registered through stages s1 to s4 and offered on pix from the last of them.
// Four register stages: tint multiply, divide by 255, blend multiply, blend sum.
// Reset clears only the stage valid bits.
// Each stage is held while the next one is full and stalled, so a stall at
// pix backs up stage by stage and empty stages still fill.
module rgba_tint_and_blend (
	input  logic      clk,
	input  logic      arst_n,
	rtb_frag_if.sink  frag,
	rtb_pix_if.source pix
);
	import rtb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	prod_t       prod_s1 [NumChan];
	rgba_t       dest_s1;
	blend_mode_t mode_s1;

	rgba_t       src_s2;
	rgba_t       dest_s2;
	blend_mode_t mode_s2;

	prod_t ps_s3 [NumColour];
	prod_t pd_s3 [NumColour];
	chan_t dcol_s3 [NumColour];
	rgba_t src_s3;
	logic  pass_s3;
	logic  add_s3;

	rgba_t res_s4;

	assign ready_s4 = !valid_s4 || pix.ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign frag.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= frag.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: texel times tint, per channel.
	always_ff @(posedge clk) begin
		if (ready_s1 && frag.valid) begin
			for (int unsigned i = 0; i < NumChan; i++) begin
				prod_s1[i] <= prod_t'(get_chan(frag.texel, i)) *
					prod_t'(get_chan(frag.tint_color, i));
			end
			dest_s1 <= frag.dest_pixel;
			mode_s1 <= frag.blend_mode;
		end
	end

	// Stage 2: scale back to eight bits, which gives the source colour.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int unsigned i = 0; i < NumChan; i++) begin
				src_s2[i*ChanW +: ChanW] <= div255(prod_s1[i]);
			end
			dest_s2 <= dest_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: weight source and destination by source alpha.
	chan_t sa_s2;
	chan_t inv_sa_s2;
	assign sa_s2     = get_chan(src_s2, AlphaChan);
	assign inv_sa_s2 = ChanMax - sa_s2;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			for (int unsigned i = 0; i < NumColour; i++) begin
				ps_s3[i]   <= prod_t'(get_chan(src_s2, i)) * prod_t'(sa_s2);
				pd_s3[i]   <= prod_t'(get_chan(dest_s2, i)) * prod_t'(inv_sa_s2);
				dcol_s3[i] <= get_chan(dest_s2, i);
			end
			src_s3  <= src_s2;
			pass_s3 <= (mode_s2 == MODE_OPAQUE) || (sa_s2 == ChanMax);
			add_s3  <= (mode_s2 == MODE_ADD);
		end
	end

	// Stage 4: pass-through, additive with saturation, or source-over average.
	rgba_t blend_s3;
	always_comb begin
		logic [ChanW:0] sum;
		blend_s3 = '0;
		blend_s3[AlphaChan*ChanW +: ChanW] = ChanMax;
		for (int unsigned i = 0; i < NumColour; i++) begin
			sum = {1'b0, dcol_s3[i]} + {1'b0, div255(ps_s3[i])};
			if (add_s3) begin
				blend_s3[i*ChanW +: ChanW] = sum[ChanW] ? ChanMax : sum[ChanW-1:0];
			end else begin
				blend_s3[i*ChanW +: ChanW] = div255(ps_s3[i] + pd_s3[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			res_s4 <= pass_s3 ? src_s3 : blend_s3;
		end
	end

	assign pix.valid        = valid_s4;
	assign pix.result_pixel = res_s4;

endmodule

// ===== hw/rtl/rtb_checker.sv =====
module rtb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input rtb_pkg::rgba_t in_texel,
	input rtb_pkg::rgba_t in_tint,
	input logic [1:0]    in_mode,
	input logic          out_valid,
	input logic          out_ready,
	input rtb_pkg::rgba_t out_pixel
);
	import rtb_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel))
		else $error("result changed while stalled");

	// With the output draining, the pipeline must be able to take a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready ##1 out_ready ##1 out_ready ##1 out_ready |-> in_ready)
		else $error("input blocked although output drained");

	// An opaque request with a full tint comes back unchanged when nothing stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_mode == MODE_OPAQUE && in_tint == '1 && out_ready)
		##1 out_ready ##1 out_ready ##1 out_ready
		|-> ##1 (out_valid && out_pixel == $past(in_texel, 4)))
		else $error("opaque pass-through mismatch");

endmodule

bind rgba_tint_and_blend rtb_checker u_rtb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frag.valid),
	.in_ready  (frag.ready),
	.in_texel  (frag.texel),
	.in_tint   (frag.tint_color),
	.in_mode   (frag.blend_mode),
	.out_valid (pix.valid),
	.out_ready (pix.ready),
	.out_pixel (pix.result_pixel)
);

// ===== sim/rgba_tint_and_blend_checker.sv =====
module rgba_tint_and_blend_checker (
	input  logic clk,
	input  logic arst_n,
	rtb_frag_if  frag,
	rtb_pix_if   pix,
	output int   errors,
	output int   pending
);
	import rtb_pkg::*;

	rgba_t expected_pixels[$];

	// Tint each channel, then blend the tinted source onto the destination.
	function automatic rgba_t blend_fragment(input rgba_t texel, input rgba_t tint,
			input rgba_t dest, input blend_mode_t mode);
		rgba_t       src;
		rgba_t       px;
		int unsigned s;
		int unsigned d;
		int unsigned a;
		int unsigned v;
		for (int i = 0; i < NumChan; i++) begin
			s = texel[i*ChanW +: ChanW];
			d = tint[i*ChanW +: ChanW];
			v = (s * d) / ChanMax;
			src[i*ChanW +: ChanW] = v[ChanW-1:0];
		end
		a = src[AlphaChan*ChanW +: ChanW];
		if (mode == MODE_OPAQUE || a == ChanMax)
			return src;
		px = '0;
		px[AlphaChan*ChanW +: ChanW] = ChanMax;
		for (int i = 0; i < NumColour; i++) begin
			s = src[i*ChanW +: ChanW];
			d = dest[i*ChanW +: ChanW];
			if (mode == MODE_ADD) begin
				v = d + (s * a) / ChanMax;
				if (v > ChanMax)
					v = ChanMax;
			end else begin
				v = (s * a + d * (ChanMax - a)) / ChanMax;
			end
			px[i*ChanW +: ChanW] = v[ChanW-1:0];
		end
		return px;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			errors <= 0;
		end else begin
			if (frag.valid && frag.ready)
				expected_pixels.push_back(blend_fragment(frag.texel, frag.tint_color,
						frag.dest_pixel, frag.blend_mode));
			if (pix.valid && pix.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result_pixel: expected none, actual %08h", pix.result_pixel);
					errors <= errors + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (pix.result_pixel !== want) begin
						$error("result_pixel: expected %08h, actual %08h", want,
								pix.result_pixel);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== sim/rgba_tint_and_blend_test.sv =====
module rgba_tint_and_blend_test;
	import rtb_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int PhaseFrags  = 333;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   src_idle;
	int   sink_idle;

	rtb_frag_if frag ();
	rtb_pix_if  pix ();

	rgba_tint_and_blend u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.frag   (frag),
		.pix    (pix)
	);

	rgba_tint_and_blend_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.frag    (frag),
		.pix     (pix),
		.errors  (errors),
		.pending (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		if (!arst_n)
			pix.ready <= 1'b0;
		else
			pix.ready <= ($urandom_range(99) >= sink_idle);
	end

	// Full scale and zero are weighted up so that opaque sources and
	// saturation turn up often in the random part.
	function automatic chan_t random_channel();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return ChanMax;
		else if (pick < 35)
			return '0;
		return chan_t'($urandom);
	endfunction

	function automatic rgba_t random_pixel();
		rgba_t px;
		for (int i = 0; i < NumChan; i++)
			px[i*ChanW +: ChanW] = random_channel();
		return px;
	endfunction

	// Holds one request on frag until it is taken; called at a rising edge.
	task automatic send_fragment(input rgba_t texel, input rgba_t tint, input rgba_t dest,
			input blend_mode_t mode);
		while ($urandom_range(99) < src_idle) begin
			frag.valid <= 1'b0;
			@(posedge clk);
		end
		frag.valid      <= 1'b1;
		frag.texel      <= texel;
		frag.tint_color <= tint;
		frag.dest_pixel <= dest;
		frag.blend_mode <= mode;
		do
			@(posedge clk);
		while (!frag.ready);
	endtask

	task automatic send_random_fragments(input int count);
		rgba_t tint;
		for (int n = 0; n < count; n++) begin
			// A quarter of the requests use a full tint.
			tint = ($urandom_range(3) == 0) ? '1 : random_pixel();
			send_fragment(random_pixel(), tint, random_pixel(),
					blend_mode_t'($urandom_range(3)));
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		src_idle        = 32;
		sink_idle       = 59;
		frag.valid      = 1'b0;
		frag.texel      = '0;
		frag.tint_color = '0;
		frag.dest_pixel = '0;
		frag.blend_mode = MODE_OPAQUE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of every field in every mode.
		for (int m = 0; m < 4; m++) begin
			send_fragment('0, '0, '0, blend_mode_t'(m));
			send_fragment('1, '1, '1, blend_mode_t'(m));
			send_fragment(32'h80ff_7f01, '1, 32'h00ff_00ff, blend_mode_t'(m));
		end
		// A tint alpha below full scale stops an opaque texel passing through.
		send_fragment(32'hff40_8020, 32'hfeff_ffff, 32'h1020_4080, MODE_ADD);
		// Additive saturation on every colour channel.
		send_fragment(32'h80ff_ffff, '1, 32'h00f0_f0f0, MODE_ADD);
		// Transparent source leaves the destination colour, alpha forced to full.
		send_fragment(32'h00ff_ffff, '1, 32'h5566_7788, MODE_ALPHA);
		send_fragment(32'h7f12_3456, 32'hc0ff_80ff, 32'haa55_aa55, MODE_ALPHA_ALT);
		// A zero tint blacks out the source whatever the texel.
		send_fragment(32'hffff_ffff, 32'h0000_0000, 32'h1234_5678, MODE_ALPHA);
		send_fragment(32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h3c3c_3c3c, MODE_OPAQUE);

		send_random_fragments(PhaseFrags);
		src_idle  = 59;
		sink_idle = 32;
		send_random_fragments(PhaseFrags);
		src_idle  = 0;
		sink_idle = 0;
		send_random_fragments(PhaseFrags);
		frag.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
